// ----- hw/rtl/fss_pkg.sv -----
package fss_pkg;

   // Event kinds carried on the request tuser
   typedef enum logic [2:0] {
      FUNC_INPUT_RECEIVED = 3'd0,
      FUNC_ACCEPTED       = 3'd1,
      FUNC_PARSE_REJECT   = 3'd2,
      FUNC_QUEUE_CLOSED   = 3'd3,
      FUNC_PROCESSED      = 3'd4,
      FUNC_READ           = 3'd5
   } func_type;

   localparam int NUM_PARSE_CODES = 6;
   localparam int NUM_EVENTS      = 4;
   localparam int NUM_ANOMALIES   = 3;
   localparam int NUM_FLAGS       = 4;

   // Event counter slots
   localparam int EVT_INPUT    = 0;
   localparam int EVT_ACCEPTED = 1;
   localparam int EVT_REJECTED = 2;
   localparam int EVT_CLOSED   = 3;

   // Sequence anomaly slots
   localparam int ANOM_MISSING   = 0;
   localparam int ANOM_DUPLICATE = 1;
   localparam int ANOM_ORDER     = 2;

   // Configuration register indexes
   localparam logic [1:0] CSR_SENSOR_MASK   = 2'd0;
   localparam logic [1:0] CSR_VOLTAGE_MASK  = 2'd1;
   localparam logic [1:0] CSR_LINK_MASK     = 2'd2;
   localparam logic [1:0] CSR_WATCHDOG_MASK = 2'd3;

   localparam logic [15:0] SENSOR_MASK_RESET   = 16'h0001;
   localparam logic [15:0] VOLTAGE_MASK_RESET  = 16'h0002;
   localparam logic [15:0] LINK_MASK_RESET     = 16'h0004;
   localparam logic [15:0] WATCHDOG_MASK_RESET = 16'h0008;

   // Statistic read indexes
   localparam logic [4:0] STAT_INPUTS      = 5'd0;
   localparam logic [4:0] STAT_ACCEPTED    = 5'd1;
   localparam logic [4:0] STAT_REJECTED    = 5'd2;
   localparam logic [4:0] STAT_CLOSED      = 5'd3;
   localparam logic [4:0] STAT_PROCESSED   = 5'd4;
   localparam logic [4:0] STAT_ERR_SIZE    = 5'd5;
   localparam logic [4:0] STAT_ERR_MAGIC   = 5'd6;
   localparam logic [4:0] STAT_ERR_VERSION = 5'd7;
   localparam logic [4:0] STAT_ERR_TYPE    = 5'd8;
   localparam logic [4:0] STAT_ERR_PAYLOAD = 5'd9;
   localparam logic [4:0] STAT_ERR_CSUM    = 5'd10;
   localparam logic [4:0] STAT_FIRST_SEQ   = 5'd11;
   localparam logic [4:0] STAT_LAST_SEQ    = 5'd12;
   localparam logic [4:0] STAT_MISSING     = 5'd13;
   localparam logic [4:0] STAT_DUPLICATE   = 5'd14;
   localparam logic [4:0] STAT_ORDER       = 5'd15;
   localparam logic [4:0] STAT_SENSOR      = 5'd16;
   localparam logic [4:0] STAT_VOLTAGE     = 5'd17;
   localparam logic [4:0] STAT_LINK        = 5'd18;
   localparam logic [4:0] STAT_WATCHDOG    = 5'd19;
   localparam logic [4:0] STAT_TEMP_MIN    = 5'd20;
   localparam logic [4:0] STAT_TEMP_MAX    = 5'd21;
   localparam logic [4:0] STAT_TEMP_SUM    = 5'd22;
   localparam logic [4:0] STAT_SUPPLY_MIN  = 5'd23;
   localparam logic [4:0] STAT_SUPPLY_MAX  = 5'd24;
   localparam logic [4:0] STAT_SUPPLY_SUM  = 5'd25;

   typedef struct packed {
      func_type           func;
      logic [2:0]         error_code;
      logic [31:0]        sequence_number;
      logic [15:0]        flag_word;
      logic signed [31:0] temperature;
      logic [15:0]        supply_voltage;
      logic [4:0]         stat_index;
   } item_type;

endpackage

// ----- hw/rtl/frame_stream_statistics_unit.sv -----
// Event statistics for a received telemetry frame stream.
//
// req channel: one transaction per event. req_tuser carries the event kind
// (input received, accepted, parse reject, queue closed, processed frame, read);
// req_tdata carries the frame fields and the statistic index of a read.
// rsp channel: one transaction per read only, with the statistic value in
// rsp_tdata and its present flag in rsp_tuser. Other events give no transaction.
// csr channel: writes of the four status flag masks; csr_ready is always high.
//
// Throughput is one event per cycle while no read waits for a full result register;
// the single update stage lies between the input register and the result register.
// A read is held in the input register, then its value is loaded into the result
// register, which drives rsp_tvalid; the value reflects every earlier event.
// While the receiver stalls, non-read events keep flowing. A read that finds the
// result register still full waits in the input register and holds req_tready
// low until the pending result is taken. Reset clears all statistics, empties
// both registers and restores the masks to their defaults (sensor 0x1,
// voltage 0x2, link 0x4, watchdog 0x8).
module frame_stream_statistics_unit #(
   parameter int COUNT_WIDTH = 48
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // error_code[2:0], sequence_number[34:3], flag_word[50:35],
   // temperature[82:51], supply_voltage[98:83], stat_index[103:99]
   input  logic [103:0]        req_tdata,
   // func[2:0]
   input  logic [2:0]          req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // stat_value[63:0]
   output logic signed [63:0]  rsp_tdata,
   // stat_present[0]
   output logic [0:0]          rsp_tuser,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_data
);

   fss_pkg::item_type item_ff, item_in;
   logic              item_vld_ff, item_vld_in;
   logic              rsp_vld_ff, rsp_vld_in;
   logic [63:0]       rsp_data_ff, rsp_data_in;
   logic              rsp_present_ff, rsp_present_in;
   logic [3:0][15:0]  mask_ff, mask_in;
   logic              rsp_free;
   logic              fire;
   logic              is_read;
   logic [63:0]       rd_value;
   logic              rd_present;

   // Unpack the request transaction
   always_comb begin
      item_in.func            = fss_pkg::func_type'(req_tuser);
      item_in.error_code      = req_tdata[2:0];
      item_in.sequence_number = req_tdata[34:3];
      item_in.flag_word       = req_tdata[50:35];
      item_in.temperature     = req_tdata[82:51];
      item_in.supply_voltage  = req_tdata[98:83];
      item_in.stat_index      = req_tdata[103:99];
   end

   // A held event retires unless it is a read and the result register is blocked
   assign is_read    = (item_ff.func == fss_pkg::FUNC_READ);
   assign rsp_free   = !rsp_vld_ff || rsp_tready;
   assign fire       = item_vld_ff && (!is_read || rsp_free);
   assign req_tready = !item_vld_ff || fire;
   assign csr_ready  = 1'b1;

   always_comb begin
      item_vld_in = item_vld_ff;
      if (req_tready) item_vld_in = req_tvalid;
   end

   // Load a new result on a retiring read, drop the old one once taken
   always_comb begin
      rsp_vld_in     = rsp_vld_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_present_in = rsp_present_ff;
      if (fire && is_read) begin
         rsp_vld_in     = 1'b1;
         rsp_data_in    = rd_value;
         rsp_present_in = rd_present;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_comb begin
      mask_in = mask_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            fss_pkg::CSR_SENSOR_MASK:   mask_in[0] = csr_data;
            fss_pkg::CSR_VOLTAGE_MASK:  mask_in[1] = csr_data;
            fss_pkg::CSR_LINK_MASK:     mask_in[2] = csr_data;
            fss_pkg::CSR_WATCHDOG_MASK: mask_in[3] = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         mask_ff[0]  <= fss_pkg::SENSOR_MASK_RESET;
         mask_ff[1]  <= fss_pkg::VOLTAGE_MASK_RESET;
         mask_ff[2]  <= fss_pkg::LINK_MASK_RESET;
         mask_ff[3]  <= fss_pkg::WATCHDOG_MASK_RESET;
      end else begin
         item_vld_ff <= item_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         mask_ff     <= mask_in;
      end
   end

   // Payload registers: no reset
   always_ff @(posedge clock) begin
      if (req_tready) item_ff <= item_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_present_ff <= rsp_present_in;
   end

   fss_stats_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .update     (fire),
      .item       (item_ff),
      .masks      (mask_ff),
      .rd_value   (rd_value),
      .rd_present (rd_present)
   );

   assign rsp_tvalid   = rsp_vld_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_present_ff;

endmodule

// ----- hw/rtl/fss_stats_core.sv -----
module fss_stats_core #(
   parameter int COUNT_WIDTH = 48
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     update,
   input  fss_pkg::item_type        item,
   input  logic [3:0][15:0]         masks,
   output logic [63:0]              rd_value,
   output logic                     rd_present
);

   localparam int CW = COUNT_WIDTH;

   logic [fss_pkg::NUM_EVENTS-1:0][CW-1:0]      event_cnt_ff, event_cnt_in;
   logic [CW-1:0]                               processed_cnt_ff, processed_cnt_in;
   logic [fss_pkg::NUM_PARSE_CODES-1:0][CW-1:0] parse_cnt_ff, parse_cnt_in;
   logic [fss_pkg::NUM_ANOMALIES-1:0][CW-1:0]   anom_cnt_ff, anom_cnt_in;
   logic [fss_pkg::NUM_FLAGS-1:0][CW-1:0]       flag_cnt_ff, flag_cnt_in;
   logic                                        seen_ff, seen_in;
   logic [31:0]                                 first_seq_ff, first_seq_in;
   logic [31:0]                                 last_seq_ff, last_seq_in;
   logic signed [31:0]                          temp_low_ff, temp_low_in;
   logic signed [31:0]                          temp_high_ff, temp_high_in;
   logic [63:0]                                 temp_total_ff, temp_total_in;
   logic [15:0]                                 supply_low_ff, supply_low_in;
   logic [15:0]                                 supply_high_ff, supply_high_in;
   logic [CW-1:0]                               supply_total_ff, supply_total_in;
   logic [31:0]                                 gap;

   assign gap = item.sequence_number - last_seq_ff - 32'd1;

   always_comb begin
      event_cnt_in     = event_cnt_ff;
      processed_cnt_in = processed_cnt_ff;
      parse_cnt_in     = parse_cnt_ff;
      anom_cnt_in      = anom_cnt_ff;
      flag_cnt_in      = flag_cnt_ff;
      seen_in          = seen_ff;
      first_seq_in     = first_seq_ff;
      last_seq_in      = last_seq_ff;
      temp_low_in      = temp_low_ff;
      temp_high_in     = temp_high_ff;
      temp_total_in    = temp_total_ff;
      supply_low_in    = supply_low_ff;
      supply_high_in   = supply_high_ff;
      supply_total_in  = supply_total_ff;
      if (update) begin
         case (item.func)
            fss_pkg::FUNC_INPUT_RECEIVED: begin
               event_cnt_in[fss_pkg::EVT_INPUT] = event_cnt_ff[fss_pkg::EVT_INPUT] + CW'(1);
            end
            fss_pkg::FUNC_ACCEPTED: begin
               event_cnt_in[fss_pkg::EVT_ACCEPTED] =
                  event_cnt_ff[fss_pkg::EVT_ACCEPTED] + CW'(1);
            end
            fss_pkg::FUNC_PARSE_REJECT: begin
               event_cnt_in[fss_pkg::EVT_REJECTED] =
                  event_cnt_ff[fss_pkg::EVT_REJECTED] + CW'(1);
               // code none and the unused code bump no code counter
               for (int i = 0; i < fss_pkg::NUM_PARSE_CODES; i++) begin
                  if (item.error_code == 3'(i)) begin
                     parse_cnt_in[i] = parse_cnt_ff[i] + CW'(1);
                  end
               end
            end
            fss_pkg::FUNC_QUEUE_CLOSED: begin
               event_cnt_in[fss_pkg::EVT_REJECTED] =
                  event_cnt_ff[fss_pkg::EVT_REJECTED] + CW'(1);
               event_cnt_in[fss_pkg::EVT_CLOSED] = event_cnt_ff[fss_pkg::EVT_CLOSED] + CW'(1);
            end
            fss_pkg::FUNC_PROCESSED: begin
               processed_cnt_in = processed_cnt_ff + CW'(1);
               if (!seen_ff) begin
                  first_seq_in   = item.sequence_number;
                  last_seq_in    = item.sequence_number;
                  temp_low_in    = item.temperature;
                  temp_high_in   = item.temperature;
                  supply_low_in  = item.supply_voltage;
                  supply_high_in = item.supply_voltage;
               end else begin
                  if (item.sequence_number == last_seq_ff) begin
                     anom_cnt_in[fss_pkg::ANOM_DUPLICATE] =
                        anom_cnt_ff[fss_pkg::ANOM_DUPLICATE] + CW'(1);
                  end else if (item.sequence_number > last_seq_ff) begin
                     anom_cnt_in[fss_pkg::ANOM_MISSING] =
                        CW'(64'(anom_cnt_ff[fss_pkg::ANOM_MISSING]) + 64'(gap));
                     last_seq_in = item.sequence_number;
                  end else begin
                     anom_cnt_in[fss_pkg::ANOM_ORDER] =
                        anom_cnt_ff[fss_pkg::ANOM_ORDER] + CW'(1);
                  end
                  if (item.temperature < temp_low_ff) temp_low_in = item.temperature;
                  if (item.temperature > temp_high_ff) temp_high_in = item.temperature;
                  if (item.supply_voltage < supply_low_ff) supply_low_in = item.supply_voltage;
                  if (item.supply_voltage > supply_high_ff) begin
                     supply_high_in = item.supply_voltage;
                  end
               end
               seen_in = 1'b1;
               for (int i = 0; i < fss_pkg::NUM_FLAGS; i++) begin
                  if ((item.flag_word & masks[i]) != 16'd0) begin
                     flag_cnt_in[i] = flag_cnt_ff[i] + CW'(1);
                  end
               end
               temp_total_in = temp_total_ff + {{32{item.temperature[31]}}, item.temperature};
               supply_total_in = CW'(64'(supply_total_ff) + 64'(item.supply_voltage));
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         event_cnt_ff     <= '0;
         processed_cnt_ff <= '0;
         parse_cnt_ff     <= '0;
         anom_cnt_ff      <= '0;
         flag_cnt_ff      <= '0;
         seen_ff          <= 1'b0;
         first_seq_ff     <= '0;
         last_seq_ff      <= '0;
         temp_low_ff      <= '0;
         temp_high_ff     <= '0;
         temp_total_ff    <= '0;
         supply_low_ff    <= '0;
         supply_high_ff   <= '0;
         supply_total_ff  <= '0;
      end else begin
         event_cnt_ff     <= event_cnt_in;
         processed_cnt_ff <= processed_cnt_in;
         parse_cnt_ff     <= parse_cnt_in;
         anom_cnt_ff      <= anom_cnt_in;
         flag_cnt_ff      <= flag_cnt_in;
         seen_ff          <= seen_in;
         first_seq_ff     <= first_seq_in;
         last_seq_ff      <= last_seq_in;
         temp_low_ff      <= temp_low_in;
         temp_high_ff     <= temp_high_in;
         temp_total_ff    <= temp_total_in;
         supply_low_ff    <= supply_low_in;
         supply_high_ff   <= supply_high_in;
         supply_total_ff  <= supply_total_in;
      end
   end

   // Read select: frame-derived values are absent until the first processed frame, unknown indexes always
   always_comb begin
      rd_value   = 64'd0;
      rd_present = 1'b1;
      unique case (item.stat_index)
         fss_pkg::STAT_INPUTS:      rd_value = 64'(event_cnt_ff[fss_pkg::EVT_INPUT]);
         fss_pkg::STAT_ACCEPTED:    rd_value = 64'(event_cnt_ff[fss_pkg::EVT_ACCEPTED]);
         fss_pkg::STAT_REJECTED:    rd_value = 64'(event_cnt_ff[fss_pkg::EVT_REJECTED]);
         fss_pkg::STAT_CLOSED:      rd_value = 64'(event_cnt_ff[fss_pkg::EVT_CLOSED]);
         fss_pkg::STAT_PROCESSED:   rd_value = 64'(processed_cnt_ff);
         fss_pkg::STAT_ERR_SIZE:    rd_value = 64'(parse_cnt_ff[0]);
         fss_pkg::STAT_ERR_MAGIC:   rd_value = 64'(parse_cnt_ff[1]);
         fss_pkg::STAT_ERR_VERSION: rd_value = 64'(parse_cnt_ff[2]);
         fss_pkg::STAT_ERR_TYPE:    rd_value = 64'(parse_cnt_ff[3]);
         fss_pkg::STAT_ERR_PAYLOAD: rd_value = 64'(parse_cnt_ff[4]);
         fss_pkg::STAT_ERR_CSUM:    rd_value = 64'(parse_cnt_ff[5]);
         fss_pkg::STAT_FIRST_SEQ: begin
            rd_present = seen_ff;
            rd_value   = seen_ff ? 64'(first_seq_ff) : 64'd0;
         end
         fss_pkg::STAT_LAST_SEQ: begin
            rd_present = seen_ff;
            rd_value   = seen_ff ? 64'(last_seq_ff) : 64'd0;
         end
         fss_pkg::STAT_MISSING:     rd_value = 64'(anom_cnt_ff[fss_pkg::ANOM_MISSING]);
         fss_pkg::STAT_DUPLICATE:   rd_value = 64'(anom_cnt_ff[fss_pkg::ANOM_DUPLICATE]);
         fss_pkg::STAT_ORDER:       rd_value = 64'(anom_cnt_ff[fss_pkg::ANOM_ORDER]);
         fss_pkg::STAT_SENSOR:      rd_value = 64'(flag_cnt_ff[0]);
         fss_pkg::STAT_VOLTAGE:     rd_value = 64'(flag_cnt_ff[1]);
         fss_pkg::STAT_LINK:        rd_value = 64'(flag_cnt_ff[2]);
         fss_pkg::STAT_WATCHDOG:    rd_value = 64'(flag_cnt_ff[3]);
         fss_pkg::STAT_TEMP_MIN: begin
            rd_present = seen_ff;
            rd_value   = seen_ff ? {{32{temp_low_ff[31]}}, temp_low_ff} : 64'd0;
         end
         fss_pkg::STAT_TEMP_MAX: begin
            rd_present = seen_ff;
            rd_value   = seen_ff ? {{32{temp_high_ff[31]}}, temp_high_ff} : 64'd0;
         end
         fss_pkg::STAT_TEMP_SUM: begin
            rd_present = seen_ff;
            rd_value   = seen_ff ? temp_total_ff : 64'd0;
         end
         fss_pkg::STAT_SUPPLY_MIN: begin
            rd_present = seen_ff;
            rd_value   = seen_ff ? 64'(supply_low_ff) : 64'd0;
         end
         fss_pkg::STAT_SUPPLY_MAX: begin
            rd_present = seen_ff;
            rd_value   = seen_ff ? 64'(supply_high_ff) : 64'd0;
         end
         fss_pkg::STAT_SUPPLY_SUM: begin
            rd_present = seen_ff;
            rd_value   = seen_ff ? 64'(supply_total_ff) : 64'd0;
         end
         default: begin
            rd_present = 1'b0;
            rd_value   = 64'd0;
         end
      endcase
   end

endmodule

// ----- hw/rtl/fss_checker.sv -----
module fss_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic [103:0]        req_tdata,
   input logic [2:0]          req_tuser,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic signed [63:0]  rsp_tdata,
   input logic [0:0]          rsp_tuser,
   input logic                csr_valid,
   input logic                csr_ready,
   input logic [1:0]          csr_index,
   input logic [15:0]         csr_data
);

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // A stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result payload changed while stalled");

   // Reset empties both registers: no result, ready for a request
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("registers not empty after reset");

   // An absent statistic reads as zero
   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 64'sd0)
      else $error("absent statistic with non-zero value");

endmodule

bind frame_stream_statistics_unit fss_checker u_fss_checker (.*);
